[hw/rtl/ikrt_pkg.sv]
// Shared widths, codes and controller/datapath handshake types for the record table.
`timescale 1ns / 1ps

package ikrt_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 64;
  localparam int STATUS_W = 2;
  localparam int REC_W    = KEY_W + HANDLE_W;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_IDS  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                load_op;
    logic                idx_inc;
    logic                rd_next;
    logic                wr_insert;
    logic                wr_shift;
    logic                cnt_dec;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                res_issue;
    logic                res_found;
    logic                emit;
  } ikrt_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              ids_out;
    logic              empty;
    logic              match;
    logic              last_scan;
    logic              more_shift;
    logic              out_busy;
  } ikrt_sts_t;

endpackage

[hw/rtl/ikrt_ifs.sv]
// Request and response channel interfaces of the record table.
`timescale 1ns / 1ps

interface ikrt_req_if import ikrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [KEY_W-1:0]    key_id;
  logic [HANDLE_W-1:0] name_handle;

  modport source (output valid, output func, output key_id, output name_handle, input ready);
  modport sink   (input valid, input func, input key_id, input name_handle, output ready);
endinterface

interface ikrt_rsp_if import ikrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    issued_id;
  logic [HANDLE_W-1:0] found_handle;

  modport source (output valid, output status, output issued_id, output found_handle,
                  input ready);
  modport sink   (input valid, input status, input issued_id, input found_handle,
                  output ready);
endinterface

[hw/rtl/ikrt_dp.sv]
// Datapath: record memory, count, id counter, scan index and result registers.
`timescale 1ns / 1ps

module ikrt_dp import ikrt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ikrt_cmd_t           cmd,
  output ikrt_sts_t           sts,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [KEY_W-1:0]    in_key_id,
  input  logic [HANDLE_W-1:0] in_name_handle,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [KEY_W-1:0]    out_issued_id,
  output logic [HANDLE_W-1:0] out_found_handle
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [REC_W-1:0]    mem [CAPACITY];
  logic [REC_W-1:0]    rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [REC_W-1:0]    wr_data;

  logic [FUNC_W-1:0]   func_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [CW-1:0]       idx_r, idx_nxt, idx_plus1;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [KEY_W-1:0]    next_key_r, next_key_nxt;
  logic [CW:0]         idx_plus2;

  logic [STATUS_W-1:0] res_status_r;
  logic [KEY_W-1:0]    res_issued_r;
  logic [HANDLE_W-1:0] res_found_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [KEY_W-1:0]    out_issued_r;
  logic [HANDLE_W-1:0] out_found_r;

  assign idx_plus1 = idx_r + CW'(1);
  assign idx_plus2 = {1'b0, idx_r} + (CW+1)'(2);
  assign rd_addr   = cmd.rd_next ? idx_plus1[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    wr_en   = cmd.wr_insert | cmd.wr_shift;
    wr_addr = cmd.wr_insert ? cnt_r[AW-1:0] : idx_r[AW-1:0];
    wr_data = cmd.wr_insert ? {next_key_r, handle_r} : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    sts.func       = func_r;
    sts.full       = (cnt_r == CW'(CAPACITY));
    sts.ids_out    = &next_key_r;
    sts.empty      = (cnt_r == '0);
    sts.match      = (rd_data_r[REC_W-1 -: KEY_W] == key_r);
    sts.last_scan  = (idx_plus1 == cnt_r);
    sts.more_shift = (idx_plus2 < {1'b0, cnt_r});
    sts.out_busy   = out_valid_r & ~out_ready;
  end

  always_comb begin
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    next_key_nxt = next_key_r;
    if (cmd.load_op) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_plus1;
    end
    if (cmd.wr_insert) begin
      cnt_nxt      = cnt_r + CW'(1);
      next_key_nxt = next_key_r + KEY_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      next_key_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      next_key_r  <= next_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      func_r       <= in_func;
      key_r        <= in_key_id;
      handle_r     <= in_name_handle;
      res_issued_r <= '0;
      res_found_r  <= '0;
    end else begin
      if (cmd.res_issue) begin
        res_issued_r <= next_key_r;
      end
      if (cmd.res_found) begin
        res_found_r <= rd_data_r[HANDLE_W-1:0];
      end
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_issued_r <= res_issued_r;
      out_found_r  <= res_found_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_issued_id    = out_issued_r;
  assign out_found_handle = out_found_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("record count above capacity");

  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_insert |=> next_key_r == $past(next_key_r) + KEY_W'(1) && next_key_r != '0)
    else $error("id counter did not step by one or wrapped");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_issued_r == '0 && out_found_r == '0)
    else $error("failed transaction carries nonzero result fields");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> idx_plus1 < cnt_r)
    else $error("compaction shift beyond last record");

endmodule

[hw/rtl/ikrt_ctrl.sv]
// Controller state machine sequencing decode, scan, compaction and response.
`timescale 1ns / 1ps

module ikrt_ctrl import ikrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output ikrt_cmd_t cmd,
  input  ikrt_sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SRD    = 7'b0000100,
    S_SCMP   = 7'b0001000,
    S_SHR    = 7'b0010000,
    S_SHW    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_set = 1'b1;
        state_nxt   = S_FINISH;
        case (sts.func)
          FUNC_INSERT: begin
            if (sts.full) begin
              cmd.res_code = ST_FULL;
            end else if (sts.ids_out) begin
              cmd.res_code = ST_NO_IDS;
            end else begin
              cmd.res_code  = ST_OK;
              cmd.wr_insert = 1'b1;
              cmd.res_issue = 1'b1;
            end
          end
          FUNC_DELETE, FUNC_LOOKUP: begin
            cmd.res_code = ST_UNKNOWN;
            if (!sts.empty) begin
              cmd.res_set = 1'b0;
              state_nxt   = S_SRD;
            end
          end
          default: begin
            cmd.res_code = ST_UNKNOWN;
          end
        endcase
      end
      S_SRD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (sts.match) begin
          if (sts.func == FUNC_LOOKUP) begin
            cmd.res_found = 1'b1;
            cmd.res_set   = 1'b1;
            cmd.res_code  = ST_OK;
            state_nxt     = S_FINISH;
          end else if (!sts.last_scan) begin
            state_nxt = S_SHR;
          end else begin
            cmd.cnt_dec  = 1'b1;
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_OK;
            state_nxt    = S_FINISH;
          end
        end else if (sts.last_scan) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_UNKNOWN;
          state_nxt    = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_SHR: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_SHW;
      end
      S_SHW: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (sts.more_shift) begin
          state_nxt = S_SHR;
        end else begin
          cmd.cnt_dec  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          state_nxt    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("response issued over an untaken response");

endmodule

[hw/rtl/id_keyed_record_table_core.sv]
// Top level of the id-keyed record table: controller, datapath and channel hookup.
// Response valid follows the accepting edge through DECODE and FINISH for insert and rejects;
// a lookup or delete first scans, reading each record visited into a register (SRD) and
// comparing it (SCMP), and a delete hit then moves each later record down one slot (SHR, SHW).
// One transaction at a time: a new request is taken only in IDLE, after the response is
// issued, and an untaken response holds the next one back in FINISH.
// Reset (synchronous, active low) clears the record count, id counter and response valid;
// the record memory is left as is, and no clearing pass runs.
`timescale 1ns / 1ps

module id_keyed_record_table_core import ikrt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  ikrt_req_if.sink   in_req,
  ikrt_rsp_if.source out_rsp
);

  ikrt_cmd_t cmd;
  ikrt_sts_t sts;

  ikrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ikrt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_req.func),
    .in_key_id        (in_req.key_id),
    .in_name_handle   (in_req.name_handle),
    .out_ready        (out_rsp.ready),
    .out_valid        (out_rsp.valid),
    .out_status       (out_rsp.status),
    .out_issued_id    (out_rsp.issued_id),
    .out_found_handle (out_rsp.found_handle)
  );

endmodule

[bench/id_keyed_record_table_core_tb.sv]
// Self-checking bench for the id-keyed record table: directed table, then random traffic.
`timescale 1ns / 1ps

module id_keyed_record_table_core_tb;
  import ikrt_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 4 * CAP + 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    issued_id;
    logic [HANDLE_W-1:0] found_handle;
  } rsp_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [4:0]          reps;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [KEY_W-1:0]    id;
    logic [HANDLE_W-1:0] found;
  } row_t;

  localparam int PLAN_N = 23;

  // typed rows carry their answer; the rest go through table_apply
  row_t plan [PLAN_N] = '{
    '{FUNC_LOOKUP, 32'd0, 64'd0, 5'd1, 1'b1, ST_UNKNOWN, 32'd0, 64'd0},
    '{FUNC_DELETE, 32'd0, 64'd0, 5'd1, 1'b1, ST_UNKNOWN, 32'd0, 64'd0},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 64'd0, 5'd1, 1'b1, ST_UNKNOWN, 32'd0, 64'd0},
    '{FUNC_INSERT, 32'd0, 64'd0, 5'd1, 1'b1, ST_OK, 32'd0, 64'd0},
    '{FUNC_INSERT, 32'hFFFF_FFFF, {64{1'b1}}, 5'd1, 1'b1, ST_OK, 32'd1, 64'd0},
    '{FUNC_LOOKUP, 32'd1, 64'd0, 5'd1, 1'b1, ST_OK, 32'd0, {64{1'b1}}},
    '{FUNC_LOOKUP, 32'd0, {64{1'b1}}, 5'd1, 1'b1, ST_OK, 32'd0, 64'd0},
    '{FUNC_UNUSED, 32'd1, {64{1'b1}}, 5'd1, 1'b1, ST_UNKNOWN, 32'd0, 64'd0},
    '{FUNC_DELETE, 32'd0, 64'd0, 5'd1, 1'b1, ST_OK, 32'd0, 64'd0},
    '{FUNC_LOOKUP, 32'd0, 64'd0, 5'd1, 1'b1, ST_UNKNOWN, 32'd0, 64'd0},
    '{FUNC_LOOKUP, 32'd1, 64'd0, 5'd1, 1'b1, ST_OK, 32'd0, {64{1'b1}}},
    '{FUNC_INSERT, 32'd0, 64'h0123_4567_89AB_CDEF, 5'd15, 1'b0, ST_OK, 32'd0, 64'd0},
    '{FUNC_INSERT, 32'd0, 64'hDEAD_BEEF_0000_0001, 5'd1, 1'b1, ST_FULL, 32'd0, 64'd0},
    '{FUNC_DELETE, 32'd9, 64'd0, 5'd1, 1'b1, ST_OK, 32'd0, 64'd0},
    '{FUNC_LOOKUP, 32'd10, 64'd0, 5'd1, 1'b0, ST_OK, 32'd0, 64'd0},
    '{FUNC_DELETE, 32'd16, 64'd0, 5'd1, 1'b1, ST_OK, 32'd0, 64'd0},
    '{FUNC_DELETE, 32'd1, 64'd0, 5'd1, 1'b1, ST_OK, 32'd0, 64'd0},
    '{FUNC_LOOKUP, 32'd16, 64'd0, 5'd1, 1'b1, ST_UNKNOWN, 32'd0, 64'd0},
    '{FUNC_INSERT, 32'd0, 64'h5A5A_A5A5_F00F_0FF0, 5'd1, 1'b1, ST_OK, 32'd17, 64'd0},
    '{FUNC_LOOKUP, 32'd17, 64'd0, 5'd1, 1'b0, ST_OK, 32'd0, 64'd0},
    '{FUNC_LOOKUP, 32'd15, 64'd0, 5'd1, 1'b0, ST_OK, 32'd0, 64'd0},
    '{FUNC_DELETE, 32'd1, 64'd0, 5'd1, 1'b1, ST_UNKNOWN, 32'd0, 64'd0},
    '{FUNC_LOOKUP, 32'h8000_0000, 64'd0, 5'd1, 1'b1, ST_UNKNOWN, 32'd0, 64'd0}
  };

  logic clk;
  logic rst_n;

  ikrt_req_if in_req ();
  ikrt_rsp_if out_rsp ();

  id_keyed_record_table_core #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  logic [KEY_W-1:0]    tbl_keys [CAP];
  logic [HANDLE_W-1:0] tbl_handles [CAP];
  int                  tbl_count;
  logic [KEY_W-1:0]    tbl_next_id;

  rsp_t        pending_rsp [$];
  int          fail_count;
  int unsigned cycles;
  bit          req_calm;
  bit          rsp_calm;
  int          req_seq;
  int          rsp_seq;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Table behavior: returns the answer and updates the shadow table.
  // Id exhaustion needs 2^32-1 inserts, so that branch is never hit here.
  function automatic rsp_t table_apply(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                                       logic [HANDLE_W-1:0] handle);
    rsp_t r;
    int   slot;
    int   i;
    r = '{ST_UNKNOWN, '0, '0};
    slot = -1;
    for (i = 0; i < tbl_count; i++) begin
      if (slot < 0 && tbl_keys[i] == key) slot = i;
    end
    case (func)
      FUNC_INSERT: begin
        if (tbl_count >= CAP) begin
          r.status = ST_FULL;
        end else if (tbl_next_id == '1) begin
          r.status = ST_NO_IDS;
        end else begin
          tbl_keys[tbl_count] = tbl_next_id;
          tbl_handles[tbl_count] = handle;
          tbl_count++;
          r.issued_id = tbl_next_id;
          tbl_next_id++;
          r.status = ST_OK;
        end
      end
      FUNC_DELETE: begin
        if (slot >= 0) begin
          for (i = slot; i < tbl_count - 1; i++) begin
            tbl_keys[i] = tbl_keys[i + 1];
            tbl_handles[i] = tbl_handles[i + 1];
          end
          tbl_count--;
          r.status = ST_OK;
        end
      end
      FUNC_LOOKUP: begin
        if (slot >= 0) begin
          r.found_handle = tbl_handles[slot];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic issue_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                               logic [HANDLE_W-1:0] handle, logic typed, rsp_t typed_rsp);
    int   gap;
    rsp_t predicted;
    if (req_seq % 40 == 0) req_calm = ($urandom_range(0, 3) == 0);
    req_seq++;
    gap = req_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.func        <= func;
    in_req.key_id      <= key;
    in_req.name_handle <= handle;
    do @(posedge clk); while (!in_req.ready);
    predicted = table_apply(func, key, handle);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  initial begin
    in_req.valid       = 1'b0;
    in_req.func        = FUNC_INSERT;
    in_req.key_id      = '0;
    in_req.name_handle = '0;
    out_rsp.ready      = 1'b0;
    rst_n              = 1'b0;
    cycles             = 0;
    fail_count         = 0;
    tbl_count          = 0;
    tbl_next_id        = '0;
    req_seq            = 0;
    rsp_seq            = 0;
  end

  initial begin : rsp_sink
    int   gap;
    rsp_t seen;
    rsp_t want;
    @(posedge clk iff rst_n);
    forever begin
      if (rsp_seq % 40 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      rsp_seq++;
      gap = rsp_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
      seen = '{out_rsp.status, out_rsp.issued_id, out_rsp.found_handle};
      if (pending_rsp.size() == 0) begin
        flag($sformatf("unexpected response: status=%0d id=%h handle=%h",
                       seen.status, seen.issued_id, seen.found_handle));
      end else begin
        want = pending_rsp.pop_front();
        if (seen.status !== want.status)
          flag($sformatf("status: expected %0d, got %0d", want.status, seen.status));
        if (seen.issued_id !== want.issued_id)
          flag($sformatf("issued_id: expected %h, got %h", want.issued_id, seen.issued_id));
        if (seen.found_handle !== want.found_handle)
          flag($sformatf("found_handle: expected %h, got %h",
                         want.found_handle, seen.found_handle));
      end
    end
  end

  initial begin : stimulus
    int                  r;
    int                  k;
    int                  n;
    int                  pick;
    int                  sel;
    int                  insert_pct;
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < PLAN_N; r++) begin
      for (k = 0; k < plan[r].reps; k++) begin
        issue_request(plan[r].func, plan[r].key, plan[r].handle + k, plan[r].typed,
                      '{plan[r].st, plan[r].id, plan[r].found});
      end
    end

    insert_pct = 40;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate fill-heavy and drain-heavy stretches so the table swings empty to full
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 65;
          1: insert_pct = 20;
          default: insert_pct = 40;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) func = FUNC_UNUSED;
      else if (pick < 2 + insert_pct) func = FUNC_INSERT;
      else if (pick < 2 + insert_pct + (98 - insert_pct) / 2) func = FUNC_DELETE;
      else func = FUNC_LOOKUP;

      sel = $urandom_range(0, 99);
      if (sel < 70 && tbl_count > 0) key = tbl_keys[$urandom_range(0, tbl_count - 1)];
      else if (sel < 85) key = tbl_next_id - $urandom_range(0, 20);
      else key = $urandom;

      case ($urandom_range(0, 9))
        0: handle = '0;
        1: handle = '1;
        default: handle = {$urandom, $urandom};
      endcase

      issue_request(func, key, handle, 1'b0, '0);
    end

    in_req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
